// ----- src/abpc_pkg.sv -----
// ----------------------------------------------------------------------------
// abpc_pkg
// Types, constants and helpers for the high-pass / low-pass clean-up filter.
// ----------------------------------------------------------------------------
`default_nettype none

package abpc_pkg;

  // clip tail and short-clip limits
  localparam logic [23:0] MUTE_TAIL_MAX    = 24'd48000;
  localparam logic [23:0] MIN_CLIP_SAMPLES = 24'd100;

  localparam int GRID_W = 48;
  localparam int COEF_W = 34;
  localparam int OPND_W = 25;
  localparam int PROD_W = COEF_W + OPND_W;
  localparam int PART_W = PROD_W - 24;
  localparam int TERM_W = PROD_W - 4;
  localparam int SUM_W  = GRID_W + 9;

  typedef logic signed [GRID_W-1:0] grid_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [OPND_W-1:0] opnd_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [PART_W-1:0] part_t;
  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  localparam grid_t GRID_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam grid_t GRID_MIN = 48'sh8000_0000_0000;

  localparam prod_t ROUND_HALF = prod_t'(64'sd134217728);

  localparam grid_t OUT_MAX_GRID = 48'sd2147418112;
  localparam grid_t OUT_MIN_GRID = -48'sd2147483648;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WRITE
  } abpc_state_e;

  // one biquad pass of the shared multiplier
  typedef enum logic [3:0] {
    STEP_B0_LO,
    STEP_B0_HI,
    STEP_B1_LO,
    STEP_B1_HI,
    STEP_A1_LO,
    STEP_A1_HI,
    STEP_A2_LO,
    STEP_A2_HI,
    STEP_T3,
    STEP_D2
  } step_e;

  typedef enum logic [2:0] {
    CFG_HP_B0,
    CFG_HP_A1,
    CFG_HP_A2,
    CFG_LP_B0,
    CFG_LP_A1,
    CFG_LP_A2,
    CFG_CLIP_LEN
  } cfg_idx_e;

  typedef struct packed {
    logic accept;
    logic run;
    logic write;
  } ctrl_t;

  function automatic grid_t sat48(input sum_t v);
    grid_t r;
    if (v > sum_t'(GRID_MAX)) begin
      r = GRID_MAX;
    end else if (v < sum_t'(GRID_MIN)) begin
      r = GRID_MIN;
    end else begin
      r = v[GRID_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/audio_bandpass_cleanup.sv -----
// ----------------------------------------------------------------------------
// audio_bandpass_cleanup
// High-pass then low-pass biquad on 16-bit PCM, clamped, with a zeroed clip tail.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------
//  input    | in_valid_i / in_stall_o   | in_sample_i
//  output   | out_valid_o / out_stall_i | out_sample_o, last_of_clip_o
//  config   | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
//  a filtered item runs 20 sequencer steps between accept and result load:
//  16 passes of the one 34x25 multiplier, two per product, and four steps
//  that take the last term and update d2; a short clip skips the steps
//  the result register frees the input side while a result waits under
//  out_stall_i; a second finished item holds until that result is taken
//  reset is asynchronous and clears filter state, position, clip length and valid
`default_nettype none

module audio_bandpass_cleanup
  import abpc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic signed [15:0] in_sample_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic signed [15:0] out_sample_o,
  output      logic               last_of_clip_o,
  input  wire logic               cfg_valid_i,
  output      logic               cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);

  abpc_state_e state_q, state_d;
  ctrl_t       ctrl;
  step_e       step_q;
  logic        stage_q;

  logic signed [31:0] hp_b0_q, hp_a1_q, hp_a2_q, lp_b0_q, lp_a1_q, lp_a2_q;
  logic [23:0]        clip_len_q;

  grid_t hp_d1_q, hp_d2_q, lp_d1_q, lp_d2_q;
  grid_t x_q, y_q;
  term_t bx_q, t1_q, t2_q, t3_q;
  prod_t prod_q;
  part_t part_q;
  logic [23:0]        pos_q;
  logic signed [15:0] sample_q;
  logic               short_q, tail_q, last_q;

  logic               out_valid_q, out_last_q;
  logic signed [15:0] out_sample_q;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_b0_q    <= 32'sd262537392;
      hp_a1_q    <= -32'sd524945132;
      hp_a2_q    <= 32'sd256768446;
      lp_b0_q    <= 32'sd203220136;
      lp_a1_q    <= 32'sd390358572;
      lp_a2_q    <= 32'sd154085441;
      clip_len_q <= 24'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_HP_B0:    hp_b0_q    <= cfg_data_i;
        CFG_HP_A1:    hp_a1_q    <= cfg_data_i;
        CFG_HP_A2:    hp_a2_q    <= cfg_data_i;
        CFG_LP_B0:    lp_b0_q    <= cfg_data_i;
        CFG_LP_A1:    lp_a1_q    <= cfg_data_i;
        CFG_LP_A2:    lp_a2_q    <= cfg_data_i;
        CFG_CLIP_LEN: clip_len_q <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // clip position decode
  logic [23:0] half_len, sil_len, tail_start;
  logic        last_now, short_now, tail_now, out_free, run_done;

  assign half_len   = {1'b0, clip_len_q[23:1]};
  assign sil_len    = (half_len > MUTE_TAIL_MAX) ? MUTE_TAIL_MAX : half_len;
  assign tail_start = clip_len_q - sil_len;
  assign last_now   = ({1'b0, pos_q} + 25'd1) >= {1'b0, clip_len_q};
  assign short_now  = clip_len_q < MIN_CLIP_SAMPLES;
  assign tail_now   = pos_q >= tail_start;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign run_done   = stage_q && (step_q == STEP_D2);

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = short_now ? ST_WRITE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (run_done) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o  = 1'b1;
    ctrl.accept = 1'b0;
    ctrl.run    = 1'b0;
    ctrl.write  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o  = 1'b0;
        ctrl.accept = in_valid_i;
      end
      ST_RUN: begin
        ctrl.run = 1'b1;
      end
      ST_WRITE: begin
        ctrl.write = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= STEP_B0_LO;
      stage_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctrl.accept) begin
        step_q  <= STEP_B0_LO;
        stage_q <= 1'b0;
      end else if (ctrl.run) begin
        if (step_q == STEP_D2) begin
          step_q  <= STEP_B0_LO;
          stage_q <= 1'b1;
        end else begin
          step_q <= step_e'(step_q + 4'd1);
        end
      end
    end
  end

  // shared multiplier operands
  logic signed [31:0] cur_b0, cur_a1, cur_a2;
  grid_t cur_d1, cur_d2, op_v;
  coef_t b0_ext, b1_ext, op_c;
  opnd_t op_b;
  logic  use_y, use_hi;
  prod_t mul_res, rnd, fin;
  term_t term;

  assign cur_b0 = stage_q ? lp_b0_q : hp_b0_q;
  assign cur_a1 = stage_q ? lp_a1_q : hp_a1_q;
  assign cur_a2 = stage_q ? lp_a2_q : hp_a2_q;
  assign cur_d1 = stage_q ? lp_d1_q : hp_d1_q;
  assign cur_d2 = stage_q ? lp_d2_q : hp_d2_q;
  assign b0_ext = coef_t'(cur_b0);
  // b1 is -2*b0 for the high-pass and +2*b0 for the low-pass
  assign b1_ext = stage_q ? (b0_ext <<< 1) : -(b0_ext <<< 1);

  always_comb begin
    op_c   = b0_ext;
    use_y  = 1'b0;
    use_hi = 1'b0;
    unique case (step_q)
      STEP_B0_LO: op_c = b0_ext;
      STEP_B0_HI: begin
        op_c   = b0_ext;
        use_hi = 1'b1;
      end
      STEP_B1_LO: op_c = b1_ext;
      STEP_B1_HI: begin
        op_c   = b1_ext;
        use_hi = 1'b1;
      end
      STEP_A1_LO: begin
        op_c  = coef_t'(cur_a1);
        use_y = 1'b1;
      end
      STEP_A1_HI: begin
        op_c   = coef_t'(cur_a1);
        use_y  = 1'b1;
        use_hi = 1'b1;
      end
      STEP_A2_LO: begin
        op_c  = coef_t'(cur_a2);
        use_y = 1'b1;
      end
      STEP_A2_HI: begin
        op_c   = coef_t'(cur_a2);
        use_y  = 1'b1;
        use_hi = 1'b1;
      end
      default: ;
    endcase
  end

  assign op_v    = use_y ? y_q : x_q;
  assign op_b    = use_hi ? {op_v[47], op_v[47:24]} : {1'b0, op_v[23:0]};
  assign mul_res = op_c * op_b;
  // low partial product with rounding, folded to the high product's grid
  assign rnd     = prod_q + ROUND_HALF;
  assign fin     = prod_q + prod_t'(part_q);
  assign term    = fin[PROD_W-1:4];

  always_ff @(posedge clk_i) begin
    prod_q <= mul_res;
    part_q <= rnd[PROD_W-1:24];
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (ctrl.accept) begin
      x_q      <= {{16{in_sample_i[15]}}, in_sample_i, 16'd0};
      sample_q <= in_sample_i;
      short_q  <= short_now;
      tail_q   <= tail_now;
      last_q   <= last_now;
    end else if (ctrl.run) begin
      unique case (step_q)
        STEP_B1_LO: bx_q <= term;
        STEP_B1_HI: y_q  <= sat48(sum_t'(bx_q) + sum_t'(cur_d1));
        STEP_A1_LO: t1_q <= term;
        STEP_A2_LO: t2_q <= term;
        STEP_T3:    t3_q <= term;
        STEP_D2: begin
          if (!stage_q) begin
            x_q <= y_q;
          end
        end
        default: ;
      endcase
    end
  end

  // filter state and clip position
  grid_t d1_new, d2_new;

  assign d1_new = sat48(sum_t'(t1_q) - sum_t'(t2_q) + sum_t'(cur_d2));
  assign d2_new = sat48(sum_t'(bx_q) - sum_t'(t3_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_d1_q <= '0;
      hp_d2_q <= '0;
      lp_d1_q <= '0;
      lp_d2_q <= '0;
      pos_q   <= 24'd0;
    end else begin
      if (ctrl.accept) begin
        pos_q <= last_now ? 24'd0 : pos_q + 24'd1;
      end
      if (ctrl.write && last_q) begin
        hp_d1_q <= '0;
        hp_d2_q <= '0;
        lp_d1_q <= '0;
        lp_d2_q <= '0;
      end else if (ctrl.run && (step_q == STEP_A2_HI)) begin
        if (stage_q) begin
          lp_d1_q <= d1_new;
        end else begin
          hp_d1_q <= d1_new;
        end
      end else if (ctrl.run && (step_q == STEP_D2)) begin
        if (stage_q) begin
          lp_d2_q <= d2_new;
        end else begin
          hp_d2_q <= d2_new;
        end
      end
    end
  end

  // clamp and truncate toward zero
  logic signed [15:0] clamped, result;

  always_comb begin
    priority if (y_q > OUT_MAX_GRID) begin
      clamped = 16'sd32767;
    end else if (y_q < OUT_MIN_GRID) begin
      clamped = -16'sd32768;
    end else if (!y_q[47] || (y_q[15:0] == 16'd0)) begin
      clamped = y_q[31:16];
    end else begin
      clamped = y_q[31:16] + 16'sd1;
    end
  end

  always_comb begin
    priority if (short_q) begin
      result = sample_q;
    end else if (tail_q) begin
      result = 16'sd0;
    end else begin
      result = clamped;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.write) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.write) begin
      out_sample_q <= result;
      out_last_q   <= last_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_sample_o   = out_sample_q;
  assign last_of_clip_o = out_last_q;

endmodule

`default_nettype wire

// ----- src/abpc_chk.sv -----
// ----------------------------------------------------------------------------
// abpc_chk
// Port-level checks for the clean-up filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module abpc_chk (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic signed [15:0] out_sample_o,
  input wire logic               last_of_clip_o
);

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_sample_o) && $stable(last_of_clip_o))
    else $error("stalled result changed");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item taken while busy");

  // a new result only ever comes out of a busy phase
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without work");

endmodule

bind audio_bandpass_cleanup abpc_chk u_abpc_chk (.*);

`default_nettype wire
